// ===== src/suffix_automaton_builder_macros.svh =====
// Assertion macros for the suffix automaton builder.
`ifndef SUFFIX_AUTOMATON_BUILDER_MACROS_SVH
`define SUFFIX_AUTOMATON_BUILDER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SAB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SAB_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SAB_ASSERT(label, clk, rst, prop, msg)
`define SAB_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== src/sab_pkg.sv =====
// Shared types for the suffix automaton builder.
package sab_pkg;
  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_RD_LAST, ST_WALK_RD, ST_WALK_CHK,
    ST_Q_RD, ST_Q_CHK, ST_CLONE_RD, ST_CLONE_WR, ST_RED_RD, ST_RED_CHK,
    ST_FIX, ST_SUM_RD, ST_SUM, ST_OUT
  } sab_state_t;

  typedef struct packed {
    logic clear;
    logic busy;
  } sab_status_t;
endpackage

// ===== src/sab_store.sv =====
// State store: transition rows, suffix links and longest lengths.
module sab_store #(
  parameter int STATE_W = 11,
  parameter int ALPHABET = 26,
  parameter int LINK_W = 12,
  parameter int LEN_W = 11
) (
  input  logic                         clk,
  input  logic                         row_we,
  input  logic [STATE_W-1:0]           row_waddr,
  input  logic [ALPHABET*STATE_W-1:0]  row_wdata,
  input  logic [STATE_W-1:0]           row_raddr,
  output logic [ALPHABET*STATE_W-1:0]  row_rdata,
  input  logic                         link_we,
  input  logic [STATE_W-1:0]           link_waddr,
  input  logic [LINK_W-1:0]            link_wdata,
  input  logic [STATE_W-1:0]           link_raddr,
  output logic [LINK_W-1:0]            link_rdata,
  input  logic                         len_we,
  input  logic [STATE_W-1:0]           len_waddr,
  input  logic [LEN_W-1:0]             len_wdata,
  input  logic [STATE_W-1:0]           len_raddr,
  output logic [LEN_W-1:0]             len_rdata
);
  localparam int DEPTH = 1 << STATE_W;
  logic [ALPHABET*STATE_W-1:0] rows [DEPTH];
  logic [LINK_W-1:0]           links [DEPTH];
  logic [LEN_W-1:0]            lens [DEPTH];

  always_ff @(posedge clk) begin
    if (row_we) begin
      rows[row_waddr] <= row_wdata;
    end
    row_rdata <= rows[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      links[link_waddr] <= link_wdata;
    end
    link_rdata <= links[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      lens[len_waddr] <= len_wdata;
    end
    len_rdata <= lens[len_raddr];
  end
endmodule

// ===== src/suffix_automaton_builder.sv =====
// Suffix automaton builder: one letter an item, built by a sequencer over one store.
// A transition to the new state is added at each state on the suffix-link walk that has
// none; the walk stops on an existing transition, and a clone is split when its target's
// length is not one more than that state's. An ignored letter gives a result with overflow.
// One item at a time: the next item is taken the cycle after the result is taken, but
// after reset, and after an end-of-string item, the root row is first cleared in one write;
// the new state's row is cleared when allocated, and a clone's row is copied from its source.
module suffix_automaton_builder #(
  parameter int MAX_STATES = 2048,
  parameter int ALPHABET = 26,
  parameter int MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  symbol,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] new_state,
  output logic [11:0] state_total,
  output logic        clone_made,
  output logic [10:0] prefix_length,
  output logic [19:0] distinct_substrings,
  output logic        overflow
);
  import sab_pkg::*;
  `include "suffix_automaton_builder_macros.svh"

  localparam int SW = $clog2(MAX_STATES);
  localparam int CW = SW + 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int RW = ALPHABET * SW;
  localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

  sab_state_t state, state_next;
  sab_status_t status;

  logic [AW-1:0] sym;
  logic          eos;
  logic [SW-1:0] last, cur, p, q, cl;
  logic          p_none;
  logic [CW-1:0] count;
  logic [19:0]   total;
  logic [LW-1:0] plen, lenp;
  logic [RW-1:0] rowbuf;
  logic          clone;
  logic          ovf;
  logic          added;
  logic          len_full;

  logic          row_we, link_we, len_we;
  logic [SW-1:0] row_waddr, row_raddr, link_waddr, link_raddr, len_waddr, len_raddr;
  logic [RW-1:0] row_wdata, row_rdata;
  logic [CW-1:0] link_wdata, link_rdata;
  logic [LW-1:0] len_wdata, len_rdata;

  sab_store #(.STATE_W(SW), .ALPHABET(ALPHABET), .LINK_W(CW), .LEN_W(LW)) u_store (
    .clk, .row_we, .row_waddr, .row_wdata, .row_raddr, .row_rdata,
    .link_we, .link_waddr, .link_wdata, .link_raddr, .link_rdata,
    .len_we, .len_waddr, .len_wdata, .len_raddr, .len_rdata
  );

  logic [SW-1:0] tr;
  assign tr = row_rdata[sym*SW +: SW];
  logic          lnk_none;
  assign lnk_none = link_rdata[CW-1];
  assign len_full = (32'(len_rdata) + 32'd1 > 32'(MAX_LEN));

  function automatic logic [RW-1:0] put(input logic [RW-1:0] r, input logic [AW-1:0] s,
                                        input logic [SW-1:0] v);
    logic [RW-1:0] o;
    o = r;
    o[s*SW +: SW] = v;
    return o;
  endfunction

  assign status.clear = (state == ST_CLEAR);
  assign status.busy  = (state != ST_IDLE);
  assign in_ready  = !status.busy;
  assign out_valid = (state == ST_OUT) && (added || ovf);
  assign new_state = 11'(last);
  assign state_total = 12'(count);
  assign clone_made = clone;
  assign prefix_length = 11'(plen);
  assign distinct_substrings = total;
  assign overflow = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    row_we = 1'b0; link_we = 1'b0; len_we = 1'b0;
    row_waddr = p; row_wdata = put(row_rdata, sym, cur);
    row_raddr = p; link_raddr = p; len_raddr = p;
    link_waddr = cur; link_wdata = '0; len_waddr = cur; len_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        row_we = 1'b1; row_waddr = '0; row_wdata = '0;
        link_we = 1'b1; link_waddr = '0; link_wdata = '1;
        len_we = 1'b1; len_waddr = '0;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        len_raddr = last;
        if (in_valid) state_next = ST_START;
      end
      ST_START: begin
        len_raddr = last;
        state_next = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        // len_rdata holds len(last)
        if (ovf || len_full) begin
          state_next = ST_OUT;
        end else begin
          row_we = 1'b1; row_waddr = cur; row_wdata = '0;
          len_we = 1'b1; len_waddr = cur; len_wdata = LW'(len_rdata + 1'b1);
          state_next = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        if (p_none) begin
          link_we = 1'b1; link_waddr = cur; link_wdata = '0;
          state_next = ST_SUM_RD;
        end else begin
          state_next = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        if (tr == '0) begin
          row_we = 1'b1;
          state_next = ST_WALK_RD;
        end else begin
          len_raddr = tr;
          state_next = ST_Q_RD;
        end
      end
      ST_Q_RD: begin
        len_raddr = q;
        state_next = ST_Q_CHK;
      end
      ST_Q_CHK: begin
        if (LW'(lenp + 1'b1) == len_rdata) begin
          link_we = 1'b1; link_waddr = cur; link_wdata = CW'(q);
          state_next = ST_SUM_RD;
        end else begin
          row_raddr = q; link_raddr = q;
          state_next = ST_CLONE_RD;
        end
      end
      ST_CLONE_RD: begin
        row_raddr = q; link_raddr = q;
        state_next = ST_CLONE_WR;
      end
      ST_CLONE_WR: begin
        // copy q's row and link into the clone, then retarget q and cur
        row_we = 1'b1; row_waddr = cl; row_wdata = row_rdata;
        link_we = 1'b1; link_waddr = cl; link_wdata = link_rdata;
        len_we = 1'b1; len_waddr = cl; len_wdata = LW'(lenp + 1'b1);
        state_next = ST_FIX;
      end
      ST_FIX: begin
        link_we = 1'b1; link_waddr = q; link_wdata = CW'(cl);
        state_next = ST_RED_RD;
      end
      ST_RED_RD: begin
        link_we = 1'b1; link_waddr = cur; link_wdata = CW'(cl);
        state_next = p_none ? ST_SUM_RD : ST_RED_CHK;
      end
      ST_RED_CHK: begin
        row_wdata = put(row_rdata, sym, cl);
        if (tr == q) begin
          row_we = 1'b1;
          state_next = ST_RED_RD;
        end else begin
          state_next = ST_SUM_RD;
        end
      end
      ST_SUM_RD: begin
        link_raddr = cur;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        len_raddr = SW'(link_rdata);
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_valid && out_ready) state_next = eos ? ST_CLEAR : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  logic [20:0] sum;
  assign sum = 21'(total) + 21'(plen) - 21'(len_rdata);

  always_ff @(posedge clk) begin
    if (rst || state == ST_CLEAR) begin
      last <= '0; count <= CW'(1); total <= '0; plen <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) begin
          sym <= AW'(symbol); eos <= end_of_string; clone <= 1'b0;
          ovf <= (symbol >= 5'(ALPHABET)) || (symbol > 5'(2**AW - 1)) ||
                 (32'(count) + 32'd2 > 32'(MAX_STATES));
          p <= last; p_none <= 1'b0; cur <= SW'(count); cl <= SW'(count + 1'b1);
        end
        ST_RD_LAST: begin
          plen <= len_rdata;
          if (len_full) ovf <= 1'b1;
          else if (!ovf) begin
            count <= count + 1'b1;
            plen <= LW'(len_rdata + 1'b1);
          end
        end
        ST_WALK_CHK: begin
          lenp <= len_rdata;
          if (tr == '0) begin
            p <= SW'(link_rdata); p_none <= lnk_none;
          end else q <= tr;
        end
        ST_CLONE_RD: begin
          count <= count + 1'b1; clone <= 1'b1;
        end
        ST_RED_CHK: if (tr == q) begin
          p <= SW'(link_rdata); p_none <= lnk_none;
        end
        ST_SUM: if (!ovf) begin
          last <= cur;
        end
        ST_OUT: if (!added && !ovf) begin
          total <= (sum > 21'(COUNT_MAX)) ? COUNT_MAX : sum[19:0];
        end
        default: ;
      endcase
    end
  end

  // hold the result back until the running total has been added
  always_ff @(posedge clk) begin
    if (rst) begin
      added <= 1'b0;
    end else if (state == ST_OUT && !added && !ovf) begin
      added <= 1'b1;
    end else if (state != ST_OUT) begin
      added <= 1'b0;
    end
  end

  `SAB_ASSERT(a_out_busy, clk, rst, out_valid |-> !in_ready, "result shown while ready")
  `SAB_ASSERT(a_clear_once, clk, rst, status.clear |=> !status.clear, "clear held")
  `SAB_ASSERT(a_count_min, clk, rst, count != '0, "state count zero")
  `SAB_ASSERT_RST(a_rst_clear, clk, $past(rst) |-> status.clear, "no clear after reset")
endmodule
